[hw/rtl/rwc_pkg.sv]
// Shared types and constants for the range window cache lookup unit.
package rwc_pkg;

	localparam int START_W  = 40;
	localparam int LEN_W    = 24;
	localparam int FSIZE_W  = 40;
	localparam int WSIZE_W  = 31;
	localparam int SLOT_W   = 4;
	localparam int CFG_W    = 40;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

	localparam logic [FSIZE_W-1:0] FILE_SIZE_RST   = 40'd0;
	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 31'd6553600;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [START_W-1:0] offset;
		logic [START_W-1:0] window_base;
		logic [WSIZE_W-1:0] window_len;
		logic               past_end;
	} rwc_result_t;

endpackage

[hw/rtl/rwc_table.sv]
// Window table: slot storage, range lookup, miss allocation and victim pointer.
module rwc_table #(
	parameter int SLOTS      = 5,
	parameter int ALIGN_BITS = 16,
	parameter int ADDR_BITS  = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_vld,
	input  logic [rwc_pkg::START_W-1:0]     req_start,
	input  logic [rwc_pkg::LEN_W-1:0]       req_len,
	input  logic [rwc_pkg::FSIZE_W-1:0]     file_size,
	input  logic [rwc_pkg::WSIZE_W-1:0]     window_size,
	output rwc_pkg::rwc_result_t            res
);
	import rwc_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] ALIGN_MASK = {{(AW-ALIGN_BITS){1'b1}}, {ALIGN_BITS{1'b0}}};
	localparam logic [PW:0] SLOTS_V = (PW+1)'(SLOTS);
	localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);

	logic [AW-1:0] base_q [SLOTS];
	logic [AW-1:0] end_q  [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [PW-1:0] ptr_q;

	logic [AW-1:0]      start_w;
	logic [AW-1:0]      aligned_w;
	logic [FSIZE_W-1:0] aligned;
	logic [FSIZE_W-1:0] room;
	logic [WSIZE_W-1:0] wlen;
	logic               past;
	logic [SLOTS-1:0]   hit_vec;
	logic [PW-1:0]      sel;
	logic               any_hit;
	logic [PW-1:0]      victim;
	logic [PW-1:0]      ptr_nxt;
	logic [AW-1:0]      end_new;

	assign start_w   = AW'(req_start);
	assign aligned_w = start_w & ALIGN_MASK;
	assign aligned   = FSIZE_W'(aligned_w);
	assign room      = file_size - aligned;
	assign past      = aligned >= file_size;

	always_comb begin
		if (past) begin
			wlen = '0;
		end else if ({{(FSIZE_W-WSIZE_W){1'b0}}, window_size} >= room) begin
			wlen = WSIZE_W'(room);
		end else begin
			wlen = window_size;
		end
	end

	assign end_new = AW'({1'b0, aligned} + {{(FSIZE_W+1-WSIZE_W){1'b0}}, wlen});

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (base_q[i] <= start_w) && (start_w <= end_q[i])
				&& (AW'(req_len) <= end_q[i] - start_w);
		end
	end

	always_comb begin
		sel = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				sel = PW'(i);
			end
		end
	end

	assign any_hit = |hit_vec;
	assign victim  = ({1'b0, ptr_q} < SLOTS_V) ? ptr_q : '0;
	assign ptr_nxt = (victim == LAST_SLOT) ? '0 : victim + PW'(1);

	always_comb begin
		if (any_hit) begin
			res.hit         = 1'b1;
			res.slot        = SLOT_W'(sel);
			res.offset      = START_W'(start_w - base_q[sel]);
			res.window_base = START_W'(base_q[sel]);
			res.window_len  = WSIZE_W'(end_q[sel] - base_q[sel]);
			res.past_end    = 1'b0;
		end else begin
			res.hit         = 1'b0;
			res.slot        = SLOT_W'(victim);
			res.offset      = START_W'(start_w - aligned_w);
			res.window_base = START_W'(aligned);
			res.window_len  = wlen;
			res.past_end    = past;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				base_q[i] <= '0;
				end_q[i]  <= '0;
			end
		end else if (req_vld && !any_hit) begin
			base_q[victim]  <= AW'(aligned);
			end_q[victim]   <= end_new;
			valid_q[victim] <= 1'b1;
			ptr_q           <= ptr_nxt;
		end
	end

endmodule

[hw/rtl/range_window_cache_lookup_unit.sv]
// Top level of the range window cache lookup unit.
//
//  channel   signals                                      handshake
//  -------   -------                                      ---------
//  request   start_addr, access_len                       start & !busy
//  result    hit, slot, offset, window_base,              done, one cycle
//            window_len, past_end
//  config    cfg_index, cfg_wdata                         cfg_we
//
//  An accepted item is held in the input register and looked up in the table; its
//  result is then registered onto the result ports, marked by done.
//  One item every cycle: busy stays low.
//  Table lookup and victim write both happen in the single stage after the
//  input register. Reset clears all slot valid bits and the victim pointer.
//  The receiver cannot stall the result.
module range_window_cache_lookup_unit #(
	parameter int SLOTS      = 5,
	parameter int ALIGN_BITS = 16,
	parameter int ADDR_BITS  = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rwc_pkg::START_W-1:0]       start_addr,
	input  logic [rwc_pkg::LEN_W-1:0]         access_len,
	output logic                              done,
	output logic                              hit,
	output logic [rwc_pkg::SLOT_W-1:0]        slot,
	output logic [rwc_pkg::START_W-1:0]       offset,
	output logic [rwc_pkg::START_W-1:0]       window_base,
	output logic [rwc_pkg::WSIZE_W-1:0]       window_len,
	output logic                              past_end,
	input  logic                              cfg_we,
	input  logic [rwc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rwc_pkg::CFG_W-1:0]         cfg_wdata
);
	import rwc_pkg::*;

	logic [FSIZE_W-1:0] file_size_q;
	logic [WSIZE_W-1:0] window_size_q;
	logic               vld_s1;
	logic [START_W-1:0] start_s1;
	logic [LEN_W-1:0]   len_s1;
	rwc_result_t        res;
	rwc_result_t        res_q;
	logic               done_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q   <= FILE_SIZE_RST;
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILE_SIZE:   file_size_q   <= FSIZE_W'(cfg_wdata);
				REG_WINDOW_SIZE: window_size_q <= WSIZE_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			start_s1 <= start_addr;
			len_s1   <= access_len;
		end
		if (vld_s1) begin
			res_q <= res;
		end
	end

	rwc_table #(
		.SLOTS      (SLOTS),
		.ALIGN_BITS (ALIGN_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_vld     (vld_s1),
		.req_start   (start_s1),
		.req_len     (len_s1),
		.file_size   (file_size_q),
		.window_size (window_size_q),
		.res         (res)
	);

	assign done        = done_q;
	assign hit         = res_q.hit;
	assign slot        = res_q.slot;
	assign offset      = res_q.offset;
	assign window_base = res_q.window_base;
	assign window_len  = res_q.window_len;
	assign past_end    = res_q.past_end;

endmodule

[tb/tb.sv]
// Self-checking bench for the range window cache lookup unit: directed and random lookups.
`timescale 1ns / 1ps

module tb;

	import rwc_pkg::*;

	localparam int SLOT_COUNT  = 5;
	localparam int ALIGN_SHIFT = 16;
	localparam int STALL_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [START_W-1:0]   start_addr = '0;
	logic [LEN_W-1:0]     access_len = '0;
	logic                 done;
	logic                 hit;
	logic [SLOT_W-1:0]    slot;
	logic [START_W-1:0]   offset;
	logic [START_W-1:0]   window_base;
	logic [WSIZE_W-1:0]   window_len;
	logic                 past_end;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// predictor copy of the configuration and the window table
	logic [FSIZE_W-1:0] cfg_fsize = FILE_SIZE_RST;
	logic [WSIZE_W-1:0] cfg_wsize = WINDOW_SIZE_RST;
	logic [START_W-1:0] win_base [SLOT_COUNT] = '{default: '0};
	logic [START_W-1:0] win_end [SLOT_COUNT] = '{default: '0};
	logic               win_valid [SLOT_COUNT] = '{default: 1'b0};
	int                 victim_ptr = 0;

	rwc_result_t predicted_lookups[$];
	rwc_result_t head;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          stall_cycles = 0;
	bit          idle_on = 1'b1;

	range_window_cache_lookup_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_addr(start_addr),
		.access_len(access_len),
		.done(done),
		.hit(hit),
		.slot(slot),
		.offset(offset),
		.window_base(window_base),
		.window_len(window_len),
		.past_end(past_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic rwc_result_t lookup_window(input logic [START_W-1:0] addr,
			input logic [LEN_W-1:0] len);
		rwc_result_t r;
		logic [START_W-1:0] aligned;
		logic [START_W-1:0] room;
		logic [START_W-1:0] wlen;
		logic [START_W-1:0] extent;
		int v;
		r = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (win_valid[s] && win_base[s] <= addr && addr <= win_end[s] &&
					{16'd0, len} <= win_end[s] - addr) begin
				extent = win_end[s] - win_base[s];
				r.hit = 1'b1;
				r.slot = s[SLOT_W-1:0];
				r.offset = addr - win_base[s];
				r.window_base = win_base[s];
				r.window_len = extent[WSIZE_W-1:0];
				return r;
			end
		end
		aligned = addr & ~((40'd1 << ALIGN_SHIFT) - 40'd1);
		if (aligned >= cfg_fsize) begin
			wlen = '0;
			r.past_end = 1'b1;
		end else begin
			room = cfg_fsize - aligned;
			wlen = ({9'd0, cfg_wsize} >= room) ? room : {9'd0, cfg_wsize};
		end
		v = (victim_ptr < SLOT_COUNT) ? victim_ptr : 0;
		win_base[v] = aligned;
		win_end[v] = aligned + wlen;
		win_valid[v] = 1'b1;
		victim_ptr = (v + 1 >= SLOT_COUNT) ? 0 : v + 1;
		r.slot = v[SLOT_W-1:0];
		r.offset = addr - aligned;
		r.window_base = aligned;
		r.window_len = wlen[WSIZE_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("tb: result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (predicted_lookups.size() == 0) begin
				report_mismatch("result with no item pending");
			end else begin
				head = predicted_lookups.pop_front();
				check_field("hit", 64'(hit), 64'(head.hit));
				check_field("slot", 64'(slot), 64'(head.slot));
				check_field("offset", 64'(offset), 64'(head.offset));
				check_field("window_base", 64'(window_base), 64'(head.window_base));
				check_field("window_len", 64'(window_len), 64'(head.window_len));
				check_field("past_end", 64'(past_end), 64'(head.past_end));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_item(input logic [START_W-1:0] addr, input logic [LEN_W-1:0] len);
		int gap;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		start_addr <= addr;
		access_len <= len;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted_lookups.push_back(lookup_window(addr, len));
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (predicted_lookups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_FILE_SIZE)
			cfg_fsize = data[FSIZE_W-1:0];
		else if (idx == REG_WINDOW_SIZE)
			cfg_wsize = data[WSIZE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// reset values: empty file, every miss lands past the end
	task automatic test_reset_defaults();
		send_item(40'h0, 24'h0);
		send_item(40'h0, 24'h0);
		send_item(40'hFF_FFFF_FFFF, 24'hFF_FFFF);
	endtask

	task automatic test_file_end_clamp();
		wait_idle();
		write_reg(REG_FILE_SIZE, 40'hFF_FFFF_FFFF);
		write_reg(REG_WINDOW_SIZE, 40'd1 << 30);
		send_item(40'hFF_FFFF_FFFA, 24'd1);
		send_item(40'hFF_FFFF_FFFE, 24'd1);
		send_item(40'hFF_FFFF_FFFF, 24'd0);
		send_item(40'h00_0123_4567, 24'hFF_FFFF);
		send_item(40'h00_0123_4567, 24'hFF_FFFF);
	endtask

	// overlapping windows: the lowest holding slot must win
	task automatic test_slot_priority();
		wait_idle();
		write_reg(REG_WINDOW_SIZE, 40'd65536);
		send_item(40'h00_0123_FFF0, 24'h10);
		send_item(40'h40_0000_0000, 24'h10);
		send_item(40'h40_0000_FFF0, 24'h20);
		send_item(40'h40_0000_0100, 24'h100);
	endtask

	task automatic test_past_end();
		wait_idle();
		write_reg(REG_FILE_SIZE, 40'h40_0000_8000);
		send_item(40'h40_0000_FFFF, 24'd2);
		send_item(40'h50_0000_0000, 24'd5);
		send_item(40'h3F_FFFF_8123, 24'h01_0000);
		send_item(40'h50_0000_0000, 24'd0);
	endtask

	task automatic run_phase(input logic [FSIZE_W-1:0] fsize, input logic [WSIZE_W-1:0] wsize,
			input int count);
		logic [63:0] region;
		logic [63:0] span;
		logic [63:0] rnd;
		logic [START_W-1:0] addr;
		logic [LEN_W-1:0] len;
		int kind;
		wait_idle();
		write_reg(REG_FILE_SIZE, fsize);
		write_reg(REG_WINDOW_SIZE, {9'd0, wsize});
		rnd = {$urandom, $urandom};
		if (fsize != 0)
			region = (rnd % {24'd0, fsize}) & ~64'hFFFF;
		else
			region = rnd & 64'hFF_FFFF_0000;
		span = 64'(wsize) * 4;
		for (int i = 0; i < count; i++) begin
			if (i % 48 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 99);
			rnd = {$urandom, $urandom};
			if (kind < 55) begin
				addr = 40'(region + rnd % span);
				len = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
			end else if (kind < 70) begin
				addr = 40'((region + rnd % span) & ~64'hFFFF);
				len = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(0, 300));
			end else if (kind < 82) begin
				addr = fsize - 40'($urandom_range(0, 32'h3_0000));
				len = 24'($urandom_range(0, 2048));
			end else begin
				addr = rnd[39:0];
				len = 24'($urandom);
			end
			send_item(addr, len);
		end
	endtask

	task automatic test_random_traffic();
		logic [39:0] rnd_fsize;
		run_phase(40'hFF_FFFF_FFFF, 31'd65536, 330);
		rnd_fsize = 40'({$urandom, $urandom});
		run_phase(rnd_fsize, 31'($urandom_range(65536, 1 << 30)), 330);
		run_phase(40'($urandom_range(0, 1 << 22)), 31'd65536, 330);
		run_phase(40'd0, 31'd1 << 30, 150);
		rnd_fsize = 40'({$urandom, $urandom});
		run_phase(rnd_fsize, 31'd1 << 30, 330);
		rnd_fsize = 40'({$urandom, $urandom});
		run_phase(rnd_fsize, 31'd6553600, 330);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_file_end_clamp();
		test_slot_priority();
		test_past_end();
		test_random_traffic();
		wait_idle();
		if (mismatch_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[range_window_cache_lookup_unit.f]
hw/rtl/rwc_pkg.sv
hw/rtl/rwc_table.sv
hw/rtl/range_window_cache_lookup_unit.sv
tb/tb.sv
